@@ sv/twoi_pkg.sv @@
// ----------------------------------------------------------------------------
// twoi_pkg
// Shared types, constants and the arctangent table of the three wheel
// odometry integrator.
// ----------------------------------------------------------------------------
package twoi_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int POS_WIDTH_DEF    = 40;
   localparam int CORDIC_MAX       = 24;

   localparam int ANGLE_W   = 32;
   localparam int HEADING_W = 16;
   localparam int OUT_W     = 40;
   localparam int CFG_W     = 16;

   localparam logic [15:0] WHEEL_DIAMETER_RESET = 16'd705;

   localparam logic [1:0] REG_WHEEL_DIAMETER    = 2'd0;
   localparam logic [1:0] REG_BACK_WHEEL_OFFSET = 2'd1;
   localparam logic [1:0] REG_SIDE_WHEEL_OFFSET = 2'd2;

   localparam logic [18:0] ARC_K    = 19'd374807;
   localparam logic [24:0] TURN_K   = 25'd30541990;
   localparam logic [29:0] RATIO_K  = 30'd750987241;
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   localparam logic [15:0]        FULL_CD   = 16'd36000;
   localparam logic signed [16:0] FULL_CD_S = 17'sd36000;
   localparam logic signed [16:0] HALF_CD_S = 17'sd18000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_MUL,
      ST_WB,
      ST_CORDIC,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_ARC_M,
      OP_ARC_HI,
      OP_ARC_LO,
      OP_DH_TURN,
      OP_NUM,
      OP_LX_A,
      OP_LX_B,
      OP_LY_A,
      OP_LY_B,
      OP_HD_TURN,
      OP_GX_A,
      OP_GX_B,
      OP_GY_A,
      OP_GY_B
   } op_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ sv/twoi_req_if.sv @@
// ----------------------------------------------------------------------------
// twoi_req_if
// Sample channel: three wheel angles and the inertial heading.
// ----------------------------------------------------------------------------
interface twoi_req_if import twoi_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic signed [ANGLE_W-1:0]   left_angle;
   logic signed [ANGLE_W-1:0]   right_angle;
   logic signed [ANGLE_W-1:0]   back_angle;
   logic        [HEADING_W-1:0] heading_angle;

   modport source (output valid, left_angle, right_angle, back_angle, heading_angle,
                   input ready);
   modport sink   (input valid, left_angle, right_angle, back_angle, heading_angle,
                   output ready);
endinterface

@@ sv/twoi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// twoi_rsp_if
// Position channel: global X and Y.
// ----------------------------------------------------------------------------
interface twoi_rsp_if import twoi_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] pos_x;
   logic signed [OUT_W-1:0] pos_y;

   modport source (output valid, pos_x, pos_y, input ready);
   modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

@@ sv/three_wheel_odometry_integrator.sv @@
// ----------------------------------------------------------------------------
// three_wheel_odometry_integrator
// Arc odometry from three tracking wheels and a heading, integrated to X/Y.
// ----------------------------------------------------------------------------
// One sample is worked on at a time; req_ch.ready is high only while the
// sequencer is idle. All products run on one 32x32 multiplier, three passes
// per 64-bit product plus an issue and a writeback state for each.
// A sample with a heading change takes 20 products, two CORDIC rotations
// (at most 24 steps) and a radix-2 divider; with no heading change it
// takes 18 products and one rotation. The finished position sits in an
// output register, so the next sample is taken while it waits.
module three_wheel_odometry_integrator import twoi_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int POS_WIDTH    = POS_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   twoi_req_if.sink    req_ch,
   twoi_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NSTEP  = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;
   localparam int DIV_N  = 64;
   localparam int CNT_W  = $clog2(DIV_N + 1);
   localparam int ARC_W  = 35;
   localparam int RAT_W  = 41;
   localparam int COR_W  = 34;
   localparam int SUM_W  = ((POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W) + 1;
   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

   // control
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [1:0]        wheel_ff, wheel_in;
   logic [1:0]        mstep_ff, mstep_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              cor_sel_ff, cor_sel_in;
   logic              flip_ff, flip_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // configuration and kept state
   logic [15:0]        wheel_diameter_ff;
   logic signed [15:0] back_wheel_offset_ff;
   logic signed [15:0] side_wheel_offset_ff;
   logic [31:0]        prev_left_ff, prev_right_ff, prev_back_ff;
   logic [15:0]        prev_heading_ff;
   logic signed [POS_WIDTH-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;

   // working registers
   logic [31:0]              absda_ff [3], absda_in [3];
   logic                     dneg_ff [3], dneg_in [3];
   logic [15:0]              h_ff, h_in;
   logic signed [15:0]       dh_ff, dh_in;
   logic signed [ARC_W-1:0]  arc_ff [3], arc_in [3];
   logic signed [ARC_W-1:0]  ya_ff, ya_in;
   logic [46:0]              m_ff, m_in;
   logic [49:0]              u_ff, u_in;
   logic signed [COR_W-1:0]  sa_ff, sa_in;
   logic signed [RAT_W-1:0]  ratio_ff, ratio_in;
   logic signed [63:0]       t_ff, t_in, lx_ff, lx_in, ly_ff, ly_in;
   logic signed [COR_W-1:0]  ch_ff, ch_in, sh_ff, sh_in;
   logic signed [COR_W-1:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [63:0]              dnum_ff, dnum_in;
   logic [14:0]              drem_ff, drem_in;
   logic [63:0]              mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [63:0]              prod_ff, prod_in;
   logic signed [OUT_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;

   // combinational helpers
   logic               accept, csr_wr;
   logic [15:0]        h_red;
   logic signed [16:0] dh_raw, dh_wrap;
   logic [31:0]        da_l, da_r, da_b;
   logic [31:0]        pp_a, pp_b;
   logic [63:0]        pp;
   logic [50:0]        arc_sum;
   logic [33:0]        arc_r;
   logic signed [ARC_W:0] ya_sum;
   logic signed [COR_W-1:0] sa_abs, xs, ys, at, z_load, c_fin, s_fin;
   logic [31:0]        z32;
   logic [14:0]        dvs;
   logic [15:0]        trial;
   logic               ge;
   logic signed [63:0] g64;
   logic signed [OUT_W-1:0] gval;
   logic signed [SUM_W-1:0] sat_sum;
   logic signed [POS_WIDTH-1:0] sat_acc, sat_res;
   logic signed [63:0] acc_x64, acc_y64;

   assign accept = req_ch.valid && req_ch.ready;
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pos_x = pos_x_ff;
   assign rsp_ch.pos_y = pos_y_ff;

   always_comb begin
      case (paddr[3:2])
         REG_WHEEL_DIAMETER:    prdata = {16'd0, wheel_diameter_ff};
         REG_BACK_WHEEL_OFFSET: prdata = {16'd0, back_wheel_offset_ff};
         REG_SIDE_WHEEL_OFFSET: prdata = {16'd0, side_wheel_offset_ff};
         default:               prdata = 32'd0;
      endcase
   end

   // sample front end
   always_comb begin
      h_red  = (req_ch.heading_angle >= FULL_CD) ? req_ch.heading_angle - FULL_CD
                                                 : req_ch.heading_angle;
      dh_raw = $signed({1'b0, h_red}) - $signed({1'b0, prev_heading_ff});
      if (dh_raw > HALF_CD_S) begin
         dh_wrap = dh_raw - FULL_CD_S;
      end else if (dh_raw <= -HALF_CD_S) begin
         dh_wrap = dh_raw + FULL_CD_S;
      end else begin
         dh_wrap = dh_raw;
      end
      da_l = req_ch.left_angle  - prev_left_ff;
      da_r = req_ch.right_angle - prev_right_ff;
      da_b = req_ch.back_angle  - prev_back_ff;
   end

   // shared multiplier, low 64 bits in three passes
   always_comb begin
      case (mstep_ff)
         2'd0: begin
            pp_a = mul_a_ff[31:0];
            pp_b = mul_b_ff[31:0];
         end
         2'd1: begin
            pp_a = mul_a_ff[31:0];
            pp_b = mul_b_ff[63:32];
         end
         default: begin
            pp_a = mul_a_ff[63:32];
            pp_b = mul_b_ff[31:0];
         end
      endcase
      pp = pp_a * pp_b;
   end

   // shared helpers for writeback, cordic and divider
   always_comb begin
      arc_sum = 51'(u_ff) + 51'(prod_ff[34:16]);
      arc_r   = arc_sum[49:16];
      ya_sum  = (ARC_W+1)'(arc_ff[0]) + (ARC_W+1)'(arc_ff[1]);
      sa_abs  = sa_ff[COR_W-1] ? -sa_ff : sa_ff;
      z32     = (op_ff == OP_DH_TURN) ? prod_ff[40:9] : prod_ff[39:8];
      z_load  = COR_W'($signed(z32));
      xs      = cx_ff >>> cnt_ff[4:0];
      ys      = cy_ff >>> cnt_ff[4:0];
      at      = COR_W'($signed(atan_turn(cnt_ff[4:0])));
      c_fin   = flip_ff ? -cx_ff : cx_ff;
      s_fin   = flip_ff ? -cy_ff : cy_ff;
      dvs     = dh_ff[15] ? 15'(-dh_ff) : 15'(dh_ff);
      trial   = {drem_ff, dnum_ff[63]};
      ge      = trial >= {1'b0, dvs};
      g64     = (op_ff == OP_GX_B) ? (t_ff + $signed(prod_ff)) >>> 24
                                   : (t_ff - $signed(prod_ff)) >>> 24;
      gval    = g64[OUT_W-1:0];
      sat_acc = (op_ff == OP_GX_B) ? acc_x_ff : acc_y_ff;
      sat_sum = SUM_W'(sat_acc) + SUM_W'(gval);
      if (sat_sum > SUM_W'(POS_MAX)) begin
         sat_res = POS_MAX;
      end else if (sat_sum < SUM_W'(POS_MIN)) begin
         sat_res = POS_MIN;
      end else begin
         sat_res = sat_sum[POS_WIDTH-1:0];
      end
      acc_x64 = 64'(acc_x_ff);
      acc_y64 = 64'(acc_y_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_ISSUE;
         end
         ST_ISSUE: state_in = ST_MUL;
         ST_MUL: begin
            if (mstep_ff == 2'd2) state_in = ST_WB;
         end
         ST_WB: begin
            case (op_ff)
               OP_DH_TURN, OP_HD_TURN: state_in = ST_CORDIC;
               OP_NUM:                 state_in = ST_DIV;
               OP_GY_B:                state_in = ST_DONE;
               default:                state_in = ST_ISSUE;
            endcase
         end
         ST_CORDIC: begin
            if (cnt_ff == CNT_W'(NSTEP)) state_in = ST_ISSUE;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_N)) state_in = ST_ISSUE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and sequencer outputs
   always_comb begin
      op_in      = op_ff;
      wheel_in   = wheel_ff;
      mstep_in   = mstep_ff;
      cnt_in     = cnt_ff;
      cor_sel_in = cor_sel_ff;
      flip_in    = flip_ff;
      acc_x_in   = acc_x_ff;
      acc_y_in   = acc_y_ff;
      absda_in   = absda_ff;
      dneg_in    = dneg_ff;
      h_in       = h_ff;
      dh_in      = dh_ff;
      arc_in     = arc_ff;
      ya_in      = ya_ff;
      m_in       = m_ff;
      u_in       = u_ff;
      sa_in      = sa_ff;
      ratio_in   = ratio_ff;
      t_in       = t_ff;
      lx_in      = lx_ff;
      ly_in      = ly_ff;
      ch_in      = ch_ff;
      sh_in      = sh_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      dnum_in    = dnum_ff;
      drem_in    = drem_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      prod_in    = prod_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               absda_in[0] = da_l[31] ? -da_l : da_l;
               absda_in[1] = da_r[31] ? -da_r : da_r;
               absda_in[2] = da_b[31] ? -da_b : da_b;
               dneg_in[0]  = da_l[31];
               dneg_in[1]  = da_r[31];
               dneg_in[2]  = da_b[31];
               h_in        = h_red;
               dh_in       = dh_wrap[15:0];
               wheel_in    = 2'd0;
               op_in       = OP_ARC_M;
            end
         end
         ST_ISSUE: begin
            mstep_in = 2'd0;
            case (op_ff)
               OP_ARC_M: begin
                  mul_a_in = 64'(absda_ff[wheel_ff]);
                  mul_b_in = 64'(wheel_diameter_ff);
               end
               OP_ARC_HI: begin
                  mul_a_in = 64'(m_ff[46:16]);
                  mul_b_in = 64'(ARC_K);
               end
               OP_ARC_LO: begin
                  mul_a_in = 64'(m_ff[15:0]);
                  mul_b_in = 64'(ARC_K);
               end
               OP_DH_TURN: begin
                  mul_a_in = 64'(dh_ff);
                  mul_b_in = 64'(TURN_K);
               end
               OP_NUM: begin
                  mul_a_in = 64'(sa_abs);
                  mul_b_in = 64'(RATIO_K);
               end
               OP_LX_A: begin
                  mul_a_in = 64'(arc_ff[2]);
                  mul_b_in = 64'(ratio_ff);
               end
               OP_LX_B: begin
                  mul_a_in = 64'(back_wheel_offset_ff);
                  mul_b_in = 64'($signed({sa_ff, 1'b0}));
               end
               OP_LY_A: begin
                  mul_a_in = 64'(ya_ff);
                  mul_b_in = 64'(ratio_ff);
               end
               OP_LY_B: begin
                  mul_a_in = 64'(side_wheel_offset_ff);
                  mul_b_in = 64'($signed({sa_ff, 1'b0}));
               end
               OP_HD_TURN: begin
                  mul_a_in = 64'(h_ff);
                  mul_b_in = 64'(TURN_K);
               end
               OP_GX_A: begin
                  mul_a_in = lx_ff;
                  mul_b_in = 64'(ch_ff);
               end
               OP_GX_B: begin
                  mul_a_in = ly_ff;
                  mul_b_in = 64'(sh_ff);
               end
               OP_GY_A: begin
                  mul_a_in = ly_ff;
                  mul_b_in = 64'(ch_ff);
               end
               OP_GY_B: begin
                  mul_a_in = lx_ff;
                  mul_b_in = 64'(sh_ff);
               end
               default: begin
                  mul_a_in = 64'd0;
                  mul_b_in = 64'd0;
               end
            endcase
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd0) begin
               prod_in = pp;
            end else begin
               prod_in = prod_ff + {pp[31:0], 32'd0};
            end
         end
         ST_WB: begin
            case (op_ff)
               OP_ARC_M: begin
                  m_in  = prod_ff[46:0];
                  op_in = OP_ARC_HI;
               end
               OP_ARC_HI: begin
                  u_in  = prod_ff[49:0];
                  op_in = OP_ARC_LO;
               end
               OP_ARC_LO: begin
                  arc_in[wheel_ff] = dneg_ff[wheel_ff] ? -ARC_W'(arc_r) : ARC_W'(arc_r);
                  if (wheel_ff != 2'd2) begin
                     wheel_in = wheel_ff + 2'd1;
                     op_in    = OP_ARC_M;
                  end else begin
                     ya_in = ya_sum[ARC_W:1];
                     if (dh_ff == 16'sd0) begin
                        ratio_in = RAT_W'(32'sd16777216);
                        sa_in    = '0;
                        op_in    = OP_LX_A;
                     end else begin
                        op_in = OP_DH_TURN;
                     end
                  end
               end
               OP_DH_TURN, OP_HD_TURN: begin
                  cor_sel_in = (op_ff == OP_HD_TURN);
                  cx_in      = COR_W'(GAIN_Q30);
                  cy_in      = '0;
                  cnt_in     = '0;
                  if (z_load > $signed(COR_W'(34'sh40000000))) begin
                     cz_in   = z_load - $signed(COR_W'(34'sh80000000));
                     flip_in = 1'b1;
                  end else if (z_load < -$signed(COR_W'(34'sh40000000))) begin
                     cz_in   = z_load + $signed(COR_W'(34'sh80000000));
                     flip_in = 1'b1;
                  end else begin
                     cz_in   = z_load;
                     flip_in = 1'b0;
                  end
               end
               OP_NUM: begin
                  dnum_in = prod_ff;
                  drem_in = '0;
                  cnt_in  = '0;
               end
               OP_LX_A, OP_LY_A: begin
                  t_in  = $signed(prod_ff) >>> 24;
                  op_in = (op_ff == OP_LX_A) ? OP_LX_B : OP_LY_B;
               end
               OP_LX_B: begin
                  lx_in = t_ff + ($signed(prod_ff) >>> 30);
                  op_in = OP_LY_A;
               end
               OP_LY_B: begin
                  ly_in = t_ff + ($signed(prod_ff) >>> 30);
                  op_in = OP_HD_TURN;
               end
               OP_GX_A, OP_GY_A: begin
                  t_in  = $signed(prod_ff);
                  op_in = (op_ff == OP_GX_A) ? OP_GX_B : OP_GY_B;
               end
               OP_GX_B: begin
                  acc_x_in = sat_res;
                  op_in    = OP_GY_A;
               end
               OP_GY_B: begin
                  acc_y_in = sat_res;
               end
               default: op_in = op_ff;
            endcase
         end
         ST_CORDIC: begin
            if (cnt_ff == CNT_W'(NSTEP)) begin
               if (cor_sel_ff) begin
                  ch_in = c_fin >>> 6;
                  sh_in = s_fin >>> 6;
                  op_in = OP_GX_A;
               end else begin
                  sa_in = s_fin;
                  op_in = OP_NUM;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (!cz_ff[COR_W-1]) begin
                  cx_in = cx_ff - ys;
                  cy_in = cy_ff + xs;
                  cz_in = cz_ff - at;
               end else begin
                  cx_in = cx_ff + ys;
                  cy_in = cy_ff - xs;
                  cz_in = cz_ff + at;
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_N)) begin
               ratio_in = (sa_ff[COR_W-1] != dh_ff[15]) ? -RAT_W'(dnum_ff[60:22])
                                                        : RAT_W'(dnum_ff[60:22]);
               op_in    = OP_LX_A;
            end else begin
               cnt_in  = cnt_ff + 1'b1;
               drem_in = ge ? 15'(trial - {1'b0, dvs}) : trial[14:0];
               dnum_in = {dnum_ff[62:0], ge};
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               pos_x_in     = acc_x64[OUT_W-1:0];
               pos_y_in     = acc_y64[OUT_W-1:0];
               rsp_valid_in = 1'b1;
            end
         end
         default: op_in = op_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         op_ff                <= OP_ARC_M;
         wheel_ff             <= 2'd0;
         mstep_ff             <= 2'd0;
         cnt_ff               <= '0;
         cor_sel_ff           <= 1'b0;
         flip_ff              <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         wheel_diameter_ff    <= WHEEL_DIAMETER_RESET;
         back_wheel_offset_ff <= '0;
         side_wheel_offset_ff <= '0;
         prev_left_ff         <= '0;
         prev_right_ff        <= '0;
         prev_back_ff         <= '0;
         prev_heading_ff      <= '0;
         acc_x_ff             <= '0;
         acc_y_ff             <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         wheel_ff     <= wheel_in;
         mstep_ff     <= mstep_in;
         cnt_ff       <= cnt_in;
         cor_sel_ff   <= cor_sel_in;
         flip_ff      <= flip_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         if (csr_wr) begin
            case (paddr[3:2])
               REG_WHEEL_DIAMETER:    wheel_diameter_ff    <= pwdata[CFG_W-1:0];
               REG_BACK_WHEEL_OFFSET: back_wheel_offset_ff <= pwdata[CFG_W-1:0];
               REG_SIDE_WHEEL_OFFSET: side_wheel_offset_ff <= pwdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            prev_left_ff    <= req_ch.left_angle;
            prev_right_ff   <= req_ch.right_angle;
            prev_back_ff    <= req_ch.back_angle;
            prev_heading_ff <= h_red;
         end
      end
   end

   always_ff @(posedge clock) begin
      absda_ff <= absda_in;
      dneg_ff  <= dneg_in;
      h_ff     <= h_in;
      dh_ff    <= dh_in;
      arc_ff   <= arc_in;
      ya_ff    <= ya_in;
      m_ff     <= m_in;
      u_ff     <= u_in;
      sa_ff    <= sa_in;
      ratio_ff <= ratio_in;
      t_ff     <= t_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      ch_ff    <= ch_in;
      sh_ff    <= sh_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      dnum_ff  <= dnum_in;
      drem_ff  <= drem_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      prod_ff  <= prod_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
   end

endmodule
